### design/ddarwc_pkg.sv
// ============================================================================
// ddarwc_pkg
// Shared types and constants of the grid ray caster for one wall column.
// ============================================================================
package ddarwc_pkg;

    // Default geometry.
    localparam int MAP_SIZE_DEF = 64;
    localparam int TEX_SIZE_DEF = 64;

    // Divider widths: a 48-bit dividend covers a Q16-shifted distance numerator.
    localparam int DIV_DW = 48;
    localparam int DIV_VW = 32;

    // Fixed-point constants.
    localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
    localparam logic [15:0] LINE_SAT    = 16'hFFFF;
    localparam logic [11:0] SCREEN_RST  = 12'd480;

    // Opcodes carried on the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RAY   = 1'b1;

    // Divider request from the sequencer.
    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } div_req_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MSTEP,
        ST_MREAD,
        ST_PNUM,
        ST_PDIV,
        ST_LINE,
        ST_LDIV,
        ST_TSTEP,
        ST_TDIV,
        ST_TEXM,
        ST_FIN
    } st_t;

endpackage

### design/ddarwc_ram.sv
// ============================================================================
// ddarwc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ddarwc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/ddarwc_div.sv
// ============================================================================
// ddarwc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module ddarwc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ddarwc_pkg::div_req_t      req,
    output logic                      busy,
    output logic                      done,
    output logic [ddarwc_pkg::DIV_DW-1:0] quotient
);

    localparam int DW = ddarwc_pkg::DIV_DW;
    localparam int VW = ddarwc_pkg::DIV_VW;
    localparam int KW = $clog2(DW + 1);

    logic [KW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   rem_s;
    logic          ge;

    // Load on start, else one shift-and-subtract step while busy.
    always_comb
    begin
        rem_s     = {rem_reg, quo_reg[DW-1]};
        ge        = rem_s >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = KW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? VW'(rem_s - {1'b0, dvs_reg}) : VW'(rem_s);
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - KW'(1);
            if (cnt_reg == KW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/dda_ray_wall_column_top.sv
// ============================================================================
// dda_ray_wall_column_top
// Grid ray caster: wall bitmap in RAM, DDA march, distance and texture math.
// ============================================================================
//  channel  | direction | words
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tuser opcode: cell write or ray cast
//  m_*      | out       | one result word per ray
//  cfg_*    | in        | screen height register, written directly
//
//  After reset the map RAM is cleared one cell a cycle, all MAP_SIZE*MAP_SIZE
//  cells (4096 by default), with s_tready low.
//  A cell write goes to the RAM as the word is accepted. An accepted ray steps
//  from cell to cell (RAM read, then test), up to 2*MAP_SIZE+4 steps, then runs
//  up to three divisions on the shared divider (issue, 48 steps, result),
//  forms the texture product and loads the output.
//  One ray at a time; a finished result waits in the output register while
//  the next word is taken, and a ray stalls at its end until that slot frees.
// ============================================================================
module dda_ray_wall_column_top #(
    parameter int MAP_SIZE = ddarwc_pkg::MAP_SIZE_DEF,
    parameter int TEX_SIZE = ddarwc_pkg::TEX_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[21:0] pos_y[43:22] dir_x[61:44] dir_y[79:62]
    // side_x[111:80] side_y[143:112] step_len_x[175:144]
    // step_len_y[207:176] cell_col[213:208] cell_row[219:214]
    // cell_is_wall[220], zero fill above
    input  logic [223:0] s_tdata,
    // opcode[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // perp_distance[31:0] line_h[47:32] row_first[59:48]
    // row_last[71:60] texture_column[77:72] texture_step[109:78]
    // hit_side[110] wall_face[112:111] escaped[113], zero fill above
    output logic [119:0] m_tdata,
    input  logic         cfg_we,
    input  logic [11:0]  cfg_wdata
);

    localparam int DEPTH     = MAP_SIZE * MAP_SIZE;
    localparam int AW        = $clog2(DEPTH);
    localparam int IW        = $clog2(MAP_SIZE);
    localparam int CW        = $clog2(MAP_SIZE + 1) + 1;
    localparam int GUARD_MAX = 2 * MAP_SIZE + 4;
    localparam int GW        = $clog2(GUARD_MAX + 1);
    localparam int NW        = 40;
    localparam int DW        = ddarwc_pkg::DIV_DW;

    ddarwc_pkg::st_t state_reg, state_next;

    logic [11:0]          sh_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [119:0]         out_reg, out_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [GW-1:0]        guard_reg, guard_next;
    logic [21:0]          px_reg, px_next, py_reg, py_next;
    logic signed [17:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]          sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [31:0]          ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic signed [CW-1:0] mx_reg, mx_next, my_reg, my_next;
    logic                 side_reg, side_next, esc_reg, esc_next, skip_reg, skip_next;
    logic [1:0]           face_reg, face_next;
    logic [31:0]          perp_reg, perp_next, tstep_reg, tstep_next, prod_reg, prod_next;
    logic [15:0]          line_reg, line_next;

    // Input word fields.
    logic [21:0]        in_px, in_py;
    logic [5:0]         in_col, in_row;
    logic               start_in, cell_ok;

    // Map RAM ports.
    logic          ram_we, ram_re, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;

    // Divider.
    ddarwc_pkg::div_req_t div_req;
    logic                 div_busy, div_done;
    logic [DW-1:0]        div_q;

    // March step.
    logic                 step_x;
    logic signed [CW-1:0] nmx, nmy, stx, sty;
    logic                 inside_n;
    logic [32:0]          sum_x, sum_y;

    // Distance numerator.
    logic signed [CW-1:0] cell_c;
    logic [21:0]          pos_c;
    logic signed [17:0]   dir_c, oth_c;
    logic signed [NW-1:0] num_c;
    logic [NW-1:0]        absn_c;
    logic [17:0]          absd_c;
    logic signed [50:0]   mul_c;

    // Result assembly.
    logic [10:0]  h2;
    logic [14:0]  l2;
    logic [11:0]  ds_c, de_c;
    logic [15:0]  de_w;
    logic [15:0]  frac_c;
    logic [27:0]  tprod_c;
    logic [11:0]  t_c, tex_c;
    logic         mirror_c;

    assign in_px  = s_tdata[21:0];
    assign in_py  = s_tdata[43:22];
    assign in_col = s_tdata[213:208];
    assign in_row = s_tdata[219:214];

    assign start_in = (int'(in_px[21:16]) < MAP_SIZE) && (int'(in_py[21:16]) < MAP_SIZE);
    assign cell_ok  = (int'(in_col) < MAP_SIZE) && (int'(in_row) < MAP_SIZE);

    // Next cell of the march: cross the nearer grid line.
    assign step_x   = sdx_reg < sdy_reg;
    assign stx      = dx_reg[17] ? -CW'(1) : CW'(1);
    assign sty      = dy_reg[17] ? -CW'(1) : CW'(1);
    assign nmx      = step_x ? mx_reg + stx : mx_reg;
    assign nmy      = step_x ? my_reg : my_reg + sty;
    assign inside_n = (nmx >= 0) && (nmy >= 0) && (nmx < MAP_SIZE) && (nmy < MAP_SIZE);
    assign sum_x    = {1'b0, sdx_reg} + {1'b0, ddx_reg};
    assign sum_y    = {1'b0, sdy_reg} + {1'b0, ddy_reg};

    // Perpendicular distance numerator on the crossed axis.
    assign cell_c = side_reg ? my_reg : mx_reg;
    assign pos_c  = side_reg ? py_reg : px_reg;
    assign dir_c  = side_reg ? dy_reg : dx_reg;
    assign oth_c  = side_reg ? dx_reg : dy_reg;
    assign num_c  = (NW'(cell_c) <<< 16) - NW'(signed'({1'b0, pos_c}))
                  + (dir_c[17] ? NW'(65536) : NW'(0));
    assign absn_c = num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
    assign absd_c = dir_c[17] ? 18'(-dir_c) : 18'(dir_c);
    assign mul_c  = $signed({1'b0, perp_reg}) * oth_c;

    // Draw rows and texture column.
    assign h2       = sh_reg[11:1];
    assign l2       = line_reg[15:1];
    assign ds_c     = (15'(h2) >= l2) ? 12'(15'(h2) - l2) : 12'd0;
    assign de_w     = 16'(h2) + 16'(l2);
    assign de_c     = (de_w >= 16'(sh_reg)) ? sh_reg : de_w[11:0];
    assign frac_c   = (side_reg ? px_reg[15:0] : py_reg[15:0]) + prod_reg[31:16];
    assign tprod_c  = 28'(frac_c) * 28'(TEX_SIZE);
    assign t_c      = tprod_c[27:16];
    assign mirror_c = (!side_reg && !dx_reg[17] && (dx_reg != 18'sd0))
                    || (side_reg && dy_reg[17]);
    assign tex_c    = mirror_c ? 12'(TEX_SIZE - 1) - t_c : t_c;

    // Sequencer: next state, RAM and divider requests.
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        clr_next      = clr_reg;
        guard_next    = guard_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sdx_next      = sdx_reg;
        sdy_next      = sdy_reg;
        ddx_next      = ddx_reg;
        ddy_next      = ddy_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        side_next     = side_reg;
        face_next     = face_reg;
        esc_next      = esc_reg;
        skip_next     = skip_reg;
        perp_next     = perp_reg;
        line_next     = line_reg;
        tstep_next    = tstep_reg;
        prod_next     = prod_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = clr_reg;
        ram_wdata     = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = AW'(int'(nmy[IW-1:0]) * MAP_SIZE + int'(nmx[IW-1:0]));
        div_req       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ddarwc_pkg::ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ddarwc_pkg::ST_IDLE;
                end
            end
            ddarwc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == ddarwc_pkg::OP_RAY)
                    begin
                        px_next    = in_px;
                        py_next    = in_py;
                        dx_next    = s_tdata[61:44];
                        dy_next    = s_tdata[79:62];
                        sdx_next   = s_tdata[111:80];
                        sdy_next   = s_tdata[143:112];
                        ddx_next   = s_tdata[175:144];
                        ddy_next   = s_tdata[207:176];
                        mx_next    = CW'(signed'({1'b0, in_px[21:16]}));
                        my_next    = CW'(signed'({1'b0, in_py[21:16]}));
                        side_next  = 1'b0;
                        face_next  = 2'd0;
                        guard_next = '0;
                        esc_next   = !start_in;
                        skip_next  = !start_in;
                        state_next = start_in ? ddarwc_pkg::ST_MSTEP : ddarwc_pkg::ST_FIN;
                    end
                    else if (cell_ok)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(int'(in_row) * MAP_SIZE + int'(in_col));
                        ram_wdata = s_tdata[220];
                    end
                end
            end
            ddarwc_pkg::ST_MSTEP:
            begin
                if (guard_reg == GW'(GUARD_MAX))
                begin
                    state_next = ddarwc_pkg::ST_PNUM;
                end
                else
                begin
                    guard_next = guard_reg + GW'(1);
                    mx_next    = nmx;
                    my_next    = nmy;
                    if (step_x)
                    begin
                        sdx_next  = sum_x[32] ? ddarwc_pkg::SAT32 : sum_x[31:0];
                        side_next = 1'b0;
                        face_next = dx_reg[17] ? 2'd1 : 2'd0;
                    end
                    else
                    begin
                        sdy_next  = sum_y[32] ? ddarwc_pkg::SAT32 : sum_y[31:0];
                        side_next = 1'b1;
                        face_next = dy_reg[17] ? 2'd3 : 2'd2;
                    end
                    if (inside_n)
                    begin
                        ram_re     = 1'b1;
                        state_next = ddarwc_pkg::ST_MREAD;
                    end
                    else
                    begin
                        esc_next   = 1'b1;
                        state_next = ddarwc_pkg::ST_PNUM;
                    end
                end
            end
            ddarwc_pkg::ST_MREAD:
            begin
                state_next = ram_rdata ? ddarwc_pkg::ST_PNUM : ddarwc_pkg::ST_MSTEP;
            end
            ddarwc_pkg::ST_PNUM:
            begin
                state_next = ddarwc_pkg::ST_LINE;
                if (dir_c == 18'sd0)
                begin
                    perp_next = ddarwc_pkg::SAT32;
                end
                else if ((num_c == NW'(0)) || (num_c[NW-1] != dir_c[17]))
                begin
                    perp_next = '0;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {absn_c[31:0], 16'd0};
                    div_req.divisor  = 32'(absd_c);
                    state_next       = ddarwc_pkg::ST_PDIV;
                end
            end
            ddarwc_pkg::ST_PDIV:
            begin
                if (div_done)
                begin
                    perp_next  = (div_q[DW-1:32] != '0) ? ddarwc_pkg::SAT32 : div_q[31:0];
                    state_next = ddarwc_pkg::ST_LINE;
                end
            end
            ddarwc_pkg::ST_LINE:
            begin
                if (perp_reg == 32'd0)
                begin
                    line_next  = ddarwc_pkg::LINE_SAT;
                    state_next = ddarwc_pkg::ST_TSTEP;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'({sh_reg, 16'd0});
                    div_req.divisor  = perp_reg;
                    state_next       = ddarwc_pkg::ST_LDIV;
                end
            end
            ddarwc_pkg::ST_LDIV:
            begin
                if (div_done)
                begin
                    line_next  = (div_q[DW-1:16] != '0) ? ddarwc_pkg::LINE_SAT : div_q[15:0];
                    state_next = ddarwc_pkg::ST_TSTEP;
                end
            end
            ddarwc_pkg::ST_TSTEP:
            begin
                if (line_reg == 16'd0)
                begin
                    tstep_next = ddarwc_pkg::SAT32;
                    state_next = ddarwc_pkg::ST_TEXM;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(TEX_SIZE) << 16;
                    div_req.divisor  = 32'(line_reg);
                    state_next       = ddarwc_pkg::ST_TDIV;
                end
            end
            ddarwc_pkg::ST_TDIV:
            begin
                if (div_done)
                begin
                    tstep_next = (div_q[DW-1:32] != '0) ? ddarwc_pkg::SAT32 : div_q[31:0];
                    state_next = ddarwc_pkg::ST_TEXM;
                end
            end
            ddarwc_pkg::ST_TEXM:
            begin
                prod_next  = mul_c[31:0];
                state_next = ddarwc_pkg::ST_FIN;
            end
            ddarwc_pkg::ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (skip_reg)
                    begin
                        out_next      = '0;
                        out_next[113] = 1'b1;
                    end
                    else
                    begin
                        out_next = {6'd0, esc_reg, face_reg, side_reg, tstep_reg,
                                    tex_c[5:0], de_c, ds_c, line_reg, perp_reg};
                    end
                    state_next = ddarwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddarwc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ddarwc_pkg::ST_CLEAR;
            m_tvalid_reg <= 1'b0;
            clr_reg      <= '0;
            guard_reg    <= '0;
            sh_reg       <= ddarwc_pkg::SCREEN_RST;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            clr_reg      <= clr_next;
            guard_reg    <= guard_next;
            if (cfg_we)
            begin
                sh_reg <= cfg_wdata;
            end
        end
    end

    // Ray datapath registers.
    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sdx_reg   <= sdx_next;
        sdy_reg   <= sdy_next;
        ddx_reg   <= ddx_next;
        ddy_reg   <= ddy_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        side_reg  <= side_next;
        face_reg  <= face_next;
        esc_reg   <= esc_next;
        skip_reg  <= skip_next;
        perp_reg  <= perp_next;
        line_reg  <= line_next;
        tstep_reg <= tstep_next;
        prod_reg  <= prod_next;
    end

    // Wall bitmap.
    ddarwc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared divider for distance, line height and texture step.
    ddarwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // A map test always follows the read issued in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ddarwc_pkg::ST_MREAD |-> $past(ram_re))
        else $error("map test without a read");

    // The divider is never restarted while a division is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider restarted while busy");

    // A cell write and a march read never share a cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("map write and read collide");

    // The last drawn row never passes the screen height.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> out_reg[71:60] <= sh_reg)
        else $error("draw end beyond screen");

endmodule

### dv/tb_dda_ray_wall_column_top.sv
// ============================================================================
// tb_dda_ray_wall_column_top
// Self-checking testbench for the grid ray caster.
// A directed table covers map writes, field extremes, zero and negative
// directions, saturated side distances, walls at the map corners and rays
// that leave the map. A random part follows. It mostly uses a dense 16x16
// corner of the map so that rays often hit walls, and it runs at several
// screen heights. Every result word is checked field by field against a
// behavioral ray caster or, for one directed ray, a typed expected column.
// ============================================================================
`timescale 1ns / 100ps

module tb_dda_ray_wall_column_top;

    localparam int MAPN      = 64;
    localparam int TEXN      = 64;
    localparam int SETTLE    = 60;
    localparam int N_PHASES  = 5;
    localparam int PHASE_LEN = 124;

    // Input word fields, lowest bit last.
    typedef struct packed {
        logic [2:0]         pad;
        logic               is_wall;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [31:0]        ddy;
        logic [31:0]        ddx;
        logic [31:0]        sdy;
        logic [31:0]        sdx;
        logic signed [17:0] dir_y;
        logic signed [17:0] dir_x;
        logic [21:0]        pos_y;
        logic [21:0]        pos_x;
    } ray_in_t;

    // Result word fields, lowest bit last.
    typedef struct packed {
        logic [5:0]  pad;
        logic        escaped;
        logic [1:0]  face;
        logic        side;
        logic [31:0] tstep;
        logic [5:0]  tex;
        logic [11:0] row_last;
        logic [11:0] row_first;
        logic [15:0] line;
        logic [31:0] perp;
    } column_t;

    // One row of the directed table.
    typedef struct {
        logic    op;
        ray_in_t word;
        bit      typed;
        column_t col;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [223:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [119:0]  m_tdata;
    logic          cfg_we;
    logic [11:0]   cfg_wdata;

    bit            wall_map [MAPN*MAPN];
    int unsigned   scr_h;
    column_t       pending_cols[$];
    int            errors;
    int            n_rays;
    int            n_writes;
    int            n_hits;
    int            n_escapes;
    int            burst_left;

    dda_ray_wall_column_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Casts one ray through the mirrored map and builds the expected column.
    function automatic column_t cast_ray(ray_in_t w);
        column_t           c;
        longint            px, py, dx, dy, num, dir, un, ud;
        longint unsigned   q, prod, frac, s;
        logic [31:0]       sdx, sdy, perp, tstep;
        int                mx, my, stx, sty, side, face, esc, g;
        int unsigned       line, h, ds, de, tex;
        bit                hit;
        c = '0;
        px = w.pos_x;
        py = w.pos_y;
        dx = w.dir_x;
        dy = w.dir_y;
        sdx = w.sdx;
        sdy = w.sdy;
        mx = int'(px >> 16);
        my = int'(py >> 16);
        if (mx >= MAPN || my >= MAPN)
        begin
            c.escaped = 1'b1;
            return c;
        end
        stx = (dx < 0) ? -1 : 1;
        sty = (dy < 0) ? -1 : 1;
        side = 0;
        face = 0;
        esc = 0;
        hit = 1'b0;

        // March: always cross the nearer grid line.
        for (g = 0; g < 2 * MAPN + 4 && !hit; g++)
        begin
            if (sdx < sdy)
            begin
                s = longint'(sdx) + w.ddx;
                sdx = (s > 64'hFFFF_FFFF) ? ddarwc_pkg::SAT32 : s[31:0];
                mx += stx;
                side = 0;
                face = (stx > 0) ? 0 : 1;
            end
            else
            begin
                s = longint'(sdy) + w.ddy;
                sdy = (s > 64'hFFFF_FFFF) ? ddarwc_pkg::SAT32 : s[31:0];
                my += sty;
                side = 1;
                face = (sty > 0) ? 2 : 3;
            end
            if (mx < 0 || my < 0 || mx >= MAPN || my >= MAPN)
            begin
                esc = 1;
                break;
            end
            if (wall_map[my * MAPN + mx])
                hit = 1'b1;
        end

        // Perpendicular distance on the crossed axis.
        if (side == 0)
        begin
            num = longint'(mx) * 65536 - px + ((stx < 0) ? 65536 : 0);
            dir = dx;
        end
        else
        begin
            num = longint'(my) * 65536 - py + ((sty < 0) ? 65536 : 0);
            dir = dy;
        end
        if (dir == 0)
            perp = ddarwc_pkg::SAT32;
        else if (num == 0 || ((num < 0) != (dir < 0)))
            perp = '0;
        else
        begin
            un = (num < 0) ? -num : num;
            ud = (dir < 0) ? -dir : dir;
            q = longint'(un << 16) / longint'(ud);
            perp = (q > 64'hFFFF_FFFF) ? ddarwc_pkg::SAT32 : q[31:0];
        end

        // Projected line and clamped draw rows.
        h = scr_h;
        if (perp == 0)
            line = 65535;
        else
        begin
            q = (longint'(h) << 16) / longint'(perp);
            line = (q > 65535) ? 65535 : int'(q);
        end
        ds = (h / 2 >= line / 2) ? h / 2 - line / 2 : 0;
        de = h / 2 + line / 2;
        if (de >= h)
            de = h;

        // Texture column from the hit point on the other axis.
        if (side == 0)
            prod = longint'(perp) * longint'(dy);
        else
            prod = longint'(perp) * longint'(dx);
        frac = ((side == 0 ? longint'(py) : longint'(px)) + (prod >> 16)) & 64'hFFFF;
        tex = int'((frac * TEXN) >> 16);
        if ((side == 0 && dx > 0) || (side == 1 && dy < 0))
            tex = TEXN - 1 - tex;

        if (line == 0)
            tstep = ddarwc_pkg::SAT32;
        else
            tstep = 32'((longint'(TEXN) << 16) / line);

        c.perp      = perp;
        c.line      = line[15:0];
        c.row_first = ds[11:0];
        c.row_last  = de[11:0];
        c.tex       = tex[5:0];
        c.tstep     = tstep;
        c.side      = side[0];
        c.face      = face[1:0];
        c.escaped   = esc[0];
        return c;
    endfunction

    // Sends one word; the handshake is seen at the falling edge before it completes.
    task automatic send_word(logic op, ray_in_t w, bit typed, column_t typed_col);
        int gap;
        s_tdata  <= w;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_tready);
        if (op == ddarwc_pkg::OP_WRITE)
        begin
            wall_map[w.row * MAPN + w.col] = w.is_wall;
            n_writes++;
        end
        else
        begin
            pending_cols.push_back(typed ? typed_col : cast_ray(w));
            n_rays++;
        end
        @(posedge clk);

        // Bursts of random length with random gaps between them.
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits until the block has delivered everything and gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_cols.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_height(logic [11:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scr_h = v;
    endtask

    function automatic ray_in_t rand_word(logic op);
        ray_in_t w;
        int      mode;
        w = '0;
        mode = $urandom_range(0, 9);
        if (op == ddarwc_pkg::OP_WRITE)
        begin
            w.col = (mode < 8) ? 6'($urandom_range(0, 15)) : 6'($urandom);
            w.row = (mode < 8) ? 6'($urandom_range(0, 15)) : 6'($urandom);
            w.is_wall = ($urandom_range(0, 9) < 4);
        end
        else
        begin
            w.pos_x = 22'($urandom);
            w.pos_y = 22'($urandom);
            if (mode < 8)
            begin
                w.pos_x[21:16] = 6'($urandom_range(0, 15));
                w.pos_y[21:16] = 6'($urandom_range(0, 15));
            end
            w.dir_x = 18'($urandom);
            w.dir_y = 18'($urandom);
            if ($urandom_range(0, 15) == 0)
                w.dir_x = '0;
            if ($urandom_range(0, 15) == 0)
                w.dir_y = '0;
            if (mode < 7)
            begin
                // Plausible distances: the first crossing lies within one step.
                w.ddx = $urandom_range(0, 32'h0008_0000);
                w.ddy = $urandom_range(0, 32'h0008_0000);
                w.sdx = $urandom_range(0, w.ddx);
                w.sdy = $urandom_range(0, w.ddy);
            end
            else
            begin
                w.ddx = $urandom;
                w.ddy = $urandom;
                w.sdx = $urandom;
                w.sdy = $urandom;
            end
        end
        return w;
    endfunction

    function automatic row_t ray_row(logic [21:0] px, logic [21:0] py, logic [17:0] dx,
                                     logic [17:0] dy, logic [31:0] sdx, logic [31:0] sdy,
                                     logic [31:0] ddx, logic [31:0] ddy);
        row_t r;
        r.op = ddarwc_pkg::OP_RAY;
        r.word = '0;
        r.word.pos_x = px;
        r.word.pos_y = py;
        r.word.dir_x = dx;
        r.word.dir_y = dy;
        r.word.sdx = sdx;
        r.word.sdy = sdy;
        r.word.ddx = ddx;
        r.word.ddy = ddy;
        r.typed = 1'b0;
        r.col = '0;
        return r;
    endfunction

    function automatic row_t cell_row(int c, int rw, bit wl);
        row_t r;
        r.op = ddarwc_pkg::OP_WRITE;
        r.word = '0;
        r.word.col = c[5:0];
        r.word.row = rw[5:0];
        r.word.is_wall = wl;
        r.typed = 1'b0;
        r.col = '0;
        return r;
    endfunction

    // Receiver stalls follow a randomly redrawn duty pattern.
    initial
    begin
        int cnt;
        int period;
        int duty;
        m_tready = 1'b0;
        cnt = 0;
        period = 1;
        duty = 1;
        forever
        begin
            @(posedge clk);
            if (cnt % 64 == 0)
            begin
                period = $urandom_range(1, 8);
                duty = ($urandom_range(0, 3) == 0) ? period : $urandom_range(0, period - 1);
            end
            m_tready <= ((cnt % period) < duty) || ($urandom_range(0, 7) == 0);
            cnt++;
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result checker; a word moves at the rising edge after this sample.
    always @(negedge clk)
    begin
        column_t got;
        column_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_cols.size() == 0)
            begin
                $error("result word with no ray pending");
                errors++;
            end
            else
            begin
                want = pending_cols.pop_front();
                check_field("perp_distance", want.perp, got.perp);
                check_field("line_h", want.line, got.line);
                check_field("row_first", want.row_first, got.row_first);
                check_field("row_last", want.row_last, got.row_last);
                check_field("texture_column", want.tex, got.tex);
                check_field("texture_step", want.tstep, got.tstep);
                check_field("hit_side", want.side, got.side);
                check_field("wall_face", want.face, got.face);
                check_field("escaped", want.escaped, got.escaped);
                if (want.escaped)
                    n_escapes++;
                else
                    n_hits++;
            end
        end
    end

    // Stimulus.
    initial
    begin
        row_t        dir_tab[$];
        row_t        r;
        logic [11:0] heights [N_PHASES];
        logic        op;
        int          i;
        int          p;

        errors = 0;
        n_rays = 0;
        n_writes = 0;
        n_hits = 0;
        n_escapes = 0;
        burst_left = 0;
        scr_h = ddarwc_pkg::SCREEN_RST;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ddarwc_pkg::OP_WRITE;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        for (i = 0; i < MAPN * MAPN; i++)
            wall_map[i] = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty map, due east from (32.5, 32.5): leaves the map at column 64.
        r = ray_row(22'h20_8000, 22'h20_8000, 18'sd65536, 18'sd0, 32'd0,
                    32'hFFFF_FFFF, 32'h1_0000, 32'hFFFF_FFFF);
        r.typed = 1'b1;
        r.col = '0;
        r.col.perp = 32'd2064384;
        r.col.line = 16'd15;
        r.col.row_first = 12'd233;
        r.col.row_last = 12'd247;
        r.col.tex = 6'd31;
        r.col.tstep = 32'd279620;
        r.col.face = 2'd0;
        r.col.side = 1'b0;
        r.col.escaped = 1'b1;
        dir_tab.push_back(r);
        // Both directions zero: steps +y and +x in turn until it leaves, distance saturates.
        dir_tab.push_back(ray_row(22'h20_8000, 22'h20_8000, 18'sd0, 18'sd0, 32'd0, 32'd0,
                                  32'h1_0000, 32'h1_0000));
        // Walls at two corners, one east of center, one set then cleared; a third corner written clear.
        dir_tab.push_back(cell_row(40, 32, 1));
        dir_tab.push_back(cell_row(0, 0, 1));
        dir_tab.push_back(cell_row(63, 63, 1));
        dir_tab.push_back(cell_row(10, 20, 1));
        dir_tab.push_back(cell_row(10, 20, 0));
        dir_tab.push_back(cell_row(63, 0, 0));
        // Hits the wall east of center; then a slanted ray toward it.
        dir_tab.push_back(ray_row(22'h20_8000, 22'h20_8000, 18'sd65536, 18'sd0, 32'd0,
                                  32'hFFFF_FFFF, 32'h1_0000, 32'hFFFF_FFFF));
        dir_tab.push_back(ray_row(22'h20_4000, 22'h20_C000, 18'sd131071, 18'sd4000,
                                  32'h8000, 32'h40_0000, 32'h8000, 32'h80_0000));
        // From the far corner (a wall, never tested), most negative directions.
        dir_tab.push_back(ray_row(22'h3F_FFFF, 22'h3F_FFFF, -18'sd131072, -18'sd131072,
                                  32'h8000, 32'h8000, 32'h8000, 32'h8000));
        // From the origin going negative: out of the map on the first step.
        dir_tab.push_back(ray_row(22'h0, 22'h0, -18'sd1, -18'sd5, 32'd0, 32'd1,
                                  32'd3, 32'd3));
        // Toward the wall at the origin from (1.5, 1.5).
        dir_tab.push_back(ray_row(22'h1_8000, 22'h1_8000, -18'sd46341, -18'sd46341,
                                  32'hB505, 32'hB506, 32'h1_6A0A, 32'h1_6A0A));
        // Saturated side distances tie, so it steps y.
        dir_tab.push_back(ray_row(22'h5_1234, 22'h7_ABCD, 18'sd300, -18'sd300,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF));
        // Tiny positive direction: a huge distance, line height zero.
        dir_tab.push_back(ray_row(22'h3E_0001, 22'h1_0000, 18'sd1, 18'sd0, 32'd0,
                                  32'hFFFF_FFFF, 32'd1, 32'd0));

        write_height(ddarwc_pkg::SCREEN_RST);
        foreach (dir_tab[k])
            send_word(dir_tab[k].op, dir_tab[k].word, dir_tab[k].typed, dir_tab[k].col);
        drain();

        // Random phases, each at its own screen height.
        heights[0] = 12'd1;
        heights[1] = 12'd4095;
        heights[2] = 12'($urandom_range(1, 4095));
        heights[3] = 12'($urandom_range(100, 900));
        heights[4] = ddarwc_pkg::SCREEN_RST;
        for (p = 0; p < N_PHASES; p++)
        begin
            write_height(heights[p]);
            for (i = 0; i < PHASE_LEN; i++)
            begin
                op = ($urandom_range(0, 99) < 35) ? ddarwc_pkg::OP_WRITE : ddarwc_pkg::OP_RAY;
                send_word(op, rand_word(op), 1'b0, '0);
                // Once, hold the sender off until the block has caught up.
                if (p == 1 && i == PHASE_LEN / 2)
                    drain();
            end
            drain();
        end

        $display("Cast %0d rays (%0d walls hit, %0d left the map) and wrote %0d cells,",
                 n_rays, n_hits, n_escapes, n_writes);
        $display("over %0d phases of screen height, including 1 and 4095.", N_PHASES + 1);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
